[hw/rtl/doq_pkg.sv]
// ----------------------------------------------------------------------------
// doq_pkg
// Types and constants shared by the deadline-ordered timer queue.
// ----------------------------------------------------------------------------
package doq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int DEADLINE_W = 48;
    localparam int TIMER_W    = 32;
    localparam int OWNER_W    = 16;
    localparam int OP_W       = 2;
    localparam int COUNT_W    = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_ID  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_OWN = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK       = 2'd3;

    // Per-cell commands
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CELL_HOLD     = 3'd0;
    localparam logic [CMD_W-1:0] CELL_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CELL_POP      = 3'd2;
    localparam logic [CMD_W-1:0] CELL_MARK_ID  = 3'd3;
    localparam logic [CMD_W-1:0] CELL_MARK_OWN = 3'd4;
    localparam logic [CMD_W-1:0] CELL_COMPACT  = 3'd5;

    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [TIMER_W-1:0]    timer_ident;
        logic [OWNER_W-1:0]    instance_ident;
    } doq_entry_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        doq_entry_t       entry;
    } doq_cell_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [DEADLINE_W-1:0] deadline;
        logic [TIMER_W-1:0]    timer_ident;
        logic [OWNER_W-1:0]    instance_ident;
        logic [DEADLINE_W-1:0] now_time;
    } doq_in_item_t;

    typedef struct packed {
        logic                  fired;
        logic [TIMER_W-1:0]    fired_timer;
        logic [OWNER_W-1:0]    fired_owner;
        logic [COUNT_W-1:0]    queue_count;
        logic [COUNT_W-1:0]    removed_count;
        logic                  overflow;
        logic [DEADLINE_W-1:0] next_deadline;
    } doq_out_item_t;

endpackage

[hw/rtl/doq_cell.sv]
// ----------------------------------------------------------------------------
// doq_cell
// One slot of the sorted queue: holds an entry, trades with its neighbors.
// ----------------------------------------------------------------------------
module doq_cell
    import doq_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  doq_cell_ctrl_t ctrl,
    input  doq_entry_t     left_entry,
    input  logic           left_valid,
    input  logic           left_le,
    input  logic           left_shift,
    input  doq_entry_t     right_entry,
    input  logic           right_valid,
    input  logic           right_dead,
    output doq_entry_t     entry,
    output logic           valid,
    output logic           dead,
    output logic           le,
    output logic           shift
);

    doq_entry_t entry_reg, entry_next;
    logic       valid_reg, valid_next;
    logic       dead_reg, dead_next;

    assign le    = valid_reg && (entry_reg.deadline <= ctrl.entry.deadline);
    assign shift = dead_reg || left_shift;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        dead_next  = dead_reg;
        unique case (ctrl.cmd)
            CELL_INSERT: begin
                // keep earlier-or-equal entries, open a gap, push the rest right
                if (!le) begin
                    if (left_le) begin
                        entry_next = ctrl.entry;
                        valid_next = 1'b1;
                    end else begin
                        entry_next = left_entry;
                        valid_next = left_valid;
                    end
                end
            end
            CELL_POP: begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            CELL_MARK_ID: begin
                dead_next = valid_reg &&
                            (entry_reg.timer_ident == ctrl.entry.timer_ident);
            end
            CELL_MARK_OWN: begin
                dead_next = valid_reg &&
                            (entry_reg.instance_ident == ctrl.entry.instance_ident);
            end
            CELL_COMPACT: begin
                // close the leftmost hole: everything from it onward moves left
                if (shift) begin
                    entry_next = right_entry;
                    valid_next = right_valid;
                    dead_next  = right_dead;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dead_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            dead_reg  <= dead_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign dead  = dead_reg;

endmodule

[hw/rtl/deadline_ordered_timer_queue.sv]
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue
// Timer queue kept sorted by deadline in a row of slot cells.
// ----------------------------------------------------------------------------
//  channel  | ports                     | payload
//  ---------+---------------------------+-----------------------------
//  input    | s_valid, s_ready, s_item  | doq_in_item_t (operation...)
//  result   | m_valid, m_ready, m_item  | doq_out_item_t (one per op)
//
//  Insert and tick update the cells in the transfer cycle; the result
//  register loads from the report state. A remove marks matches in the
//  transfer cycle, then one cell shift closes each hole before the report.
//  Reset clears every slot valid flag at once; no clearing pass is needed.
//  A new item is taken while an earlier result still waits on m_ready; a
//  stalled result holds the block in its report state.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue
    import doq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  doq_in_item_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output doq_out_item_t m_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPACT = 2'd1;
    localparam logic [1:0] ST_REPORT  = 2'd2;

    logic [1:0] state_reg, state_next;

    doq_cell_ctrl_t   ctrl;
    doq_entry_t       cell_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_vld, cell_dead, cell_le, cell_shf;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic             fired_reg, fired_next;
    logic             ovf_reg, ovf_next;
    logic [TIMER_W-1:0] ftimer_reg, ftimer_next;
    logic [OWNER_W-1:0] fowner_reg, fowner_next;
    logic             m_valid_reg, m_valid_next;
    doq_out_item_t    m_item_reg, m_item_next;

    logic accept, full, any_dead, head_due;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign full     = cell_vld[QUEUE_DEPTH-1];
    assign any_dead = |cell_dead;
    assign head_due = cell_vld[0] && (cell_ent[0].deadline < s_item.now_time);

    // ---- slot chain ----
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            doq_entry_t l_ent, r_ent;
            logic       l_vld, l_le, l_shf, r_vld, r_dead;
            if (i == 0) begin : g_first
                assign l_ent = ctrl.entry;
                assign l_vld = 1'b1;
                assign l_le  = 1'b1;
                assign l_shf = 1'b0;
            end else begin : g_inner_l
                assign l_ent = cell_ent[i-1];
                assign l_vld = cell_vld[i-1];
                assign l_le  = cell_le[i-1];
                assign l_shf = cell_shf[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin : g_last
                assign r_ent  = ctrl.entry;
                assign r_vld  = 1'b0;
                assign r_dead = 1'b0;
            end else begin : g_inner_r
                assign r_ent  = cell_ent[i+1];
                assign r_vld  = cell_vld[i+1];
                assign r_dead = cell_dead[i+1];
            end
            doq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_entry  (l_ent),
                .left_valid  (l_vld),
                .left_le     (l_le),
                .left_shift  (l_shf),
                .right_entry (r_ent),
                .right_valid (r_vld),
                .right_dead  (r_dead),
                .entry       (cell_ent[i]),
                .valid       (cell_vld[i]),
                .dead        (cell_dead[i]),
                .le          (cell_le[i]),
                .shift       (cell_shf[i])
            );
        end
    endgenerate

    // ---- control ----
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        fired_next   = fired_reg;
        ovf_next     = ovf_reg;
        ftimer_next  = ftimer_reg;
        fowner_next  = fowner_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        ctrl.cmd                  = CELL_HOLD;
        ctrl.entry.deadline       = s_item.deadline;
        ctrl.entry.timer_ident    = s_item.timer_ident;
        ctrl.entry.instance_ident = s_item.instance_ident;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    removed_next = '0;
                    fired_next   = 1'b0;
                    ovf_next     = 1'b0;
                    ftimer_next  = '0;
                    fowner_next  = '0;
                    state_next   = ST_REPORT;
                    unique case (s_item.operation)
                        OP_INSERT: begin
                            if (full) begin
                                ovf_next = 1'b1;
                            end else begin
                                ctrl.cmd   = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE_ID: begin
                            ctrl.cmd   = CELL_MARK_ID;
                            state_next = ST_COMPACT;
                        end
                        OP_REMOVE_OWN: begin
                            ctrl.cmd   = CELL_MARK_OWN;
                            state_next = ST_COMPACT;
                        end
                        OP_TICK: begin
                            if (head_due) begin
                                ctrl.cmd    = CELL_POP;
                                fired_next  = 1'b1;
                                ftimer_next = cell_ent[0].timer_ident;
                                fowner_next = cell_ent[0].instance_ident;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        default: begin
                            ctrl.cmd = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_COMPACT: begin
                if (any_dead) begin
                    ctrl.cmd     = CELL_COMPACT;
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_item_next.fired          = fired_reg;
                    m_item_next.fired_timer    = ftimer_reg;
                    m_item_next.fired_owner    = fowner_reg;
                    m_item_next.queue_count    = COUNT_W'(count_reg);
                    m_item_next.removed_count  = COUNT_W'(removed_reg);
                    m_item_next.overflow       = ovf_reg;
                    m_item_next.next_deadline  = cell_vld[0] ? cell_ent[0].deadline
                                                             : '0;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        removed_reg <= removed_next;
        fired_reg   <= fired_next;
        ovf_reg     <= ovf_next;
        ftimer_reg  <= ftimer_next;
        fowner_reg  <= fowner_next;
        m_item_reg  <= m_item_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[tb/doq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doq_result_checker
// Watches both channels of the timer queue, keeps its own sorted copy of the
// pending timers, predicts the result of every operation taken in and
// compares each result that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module doq_result_checker
    import doq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  doq_in_item_t  s_item,
    input  logic          m_valid,
    input  logic          m_ready,
    input  doq_out_item_t m_item,
    output int            mismatch_count,
    output int            pending_results
);

    doq_entry_t    slots [DEPTH];
    int            held;
    doq_out_item_t expected_results [$];
    int            result_seq;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
        held            = 0;
        result_seq      = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int seq,
                               input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      seq, name, got, want));
    endtask

    task automatic predict_timer_op(input doq_in_item_t op_in,
                                    output doq_out_item_t res);
        int   pos;
        int   keep;
        logic hit;
        res = '0;
        case (op_in.operation) inside
            OP_INSERT: begin
                if (held >= DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    // equal deadlines go behind the ones already held
                    pos = 0;
                    while (pos < held && slots[pos].deadline <= op_in.deadline)
                        pos++;
                    for (int i = held; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos].deadline       = op_in.deadline;
                    slots[pos].timer_ident    = op_in.timer_ident;
                    slots[pos].instance_ident = op_in.instance_ident;
                    held++;
                end
            end
            OP_REMOVE_ID, OP_REMOVE_OWN: begin
                keep = 0;
                for (int i = 0; i < held; i++) begin
                    hit = (op_in.operation == OP_REMOVE_OWN)
                        ? (slots[i].instance_ident == op_in.instance_ident)
                        : (slots[i].timer_ident == op_in.timer_ident);
                    if (!hit) begin
                        slots[keep] = slots[i];
                        keep++;
                    end
                end
                res.removed_count = COUNT_W'(held - keep);
                held = keep;
            end
            OP_TICK: begin
                // pop only a head that is strictly overdue
                if (held > 0 && slots[0].deadline < op_in.now_time) begin
                    res.fired       = 1'b1;
                    res.fired_timer = slots[0].timer_ident;
                    res.fired_owner = slots[0].instance_ident;
                    for (int i = 1; i < held; i++)
                        slots[i-1] = slots[i];
                    held--;
                end
            end
        endcase
        res.queue_count   = COUNT_W'(held);
        res.next_deadline = (held > 0) ? slots[0].deadline : '0;
    endtask

    always @(posedge aclk) begin : watch
        doq_out_item_t want;
        doq_out_item_t predicted;
        if (!aresetn) begin
            held = 0;
            expected_results.delete();
        end else begin
            // results leaving now belong to older transfers, so compare first
            if (m_valid && m_ready) begin
                result_seq++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_seq));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("fired", result_seq, 64'(m_item.fired), 64'(want.fired));
                    check_field("fired_timer", result_seq, 64'(m_item.fired_timer),
                                64'(want.fired_timer));
                    check_field("fired_owner", result_seq, 64'(m_item.fired_owner),
                                64'(want.fired_owner));
                    check_field("queue_count", result_seq, 64'(m_item.queue_count),
                                64'(want.queue_count));
                    check_field("removed_count", result_seq, 64'(m_item.removed_count),
                                64'(want.removed_count));
                    check_field("overflow", result_seq, 64'(m_item.overflow),
                                64'(want.overflow));
                    check_field("next_deadline", result_seq, 64'(m_item.next_deadline),
                                64'(want.next_deadline));
                end
            end
            if (s_valid && s_ready) begin
                predict_timer_op(s_item, predicted);
                expected_results.insert(expected_results.size(), predicted);
            end
        end
        pending_results = expected_results.size();
    end

endmodule

[tb/deadline_ordered_timer_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_tb
// Drives inserts, removes and ticks into the timer queue: a directed opening
// over the corner cases, then random traffic in phases with and without
// idle cycles on either side, including one long result back-pressure.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue_tb;
    import doq_pkg::*;

    localparam int RANDOM_PER_PHASE = 384;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 40;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    doq_in_item_t  s_item  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    doq_out_item_t m_item;

    int mismatch_count;
    int pending_results;

    // receiver controls
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    // sender controls and traffic shaping
    int          tx_idle_pct = 0;
    int          insert_pct  = 50;
    logic [47:0] base_time   = 48'd1000;
    logic [31:0] timer_pool [8];
    logic [15:0] owner_pool [4];

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    deadline_ordered_timer_queue #(
        .QUEUE_DEPTH (DEPTH_DEFAULT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    doq_result_checker #(
        .DEPTH (DEPTH_DEFAULT)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_req;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    task automatic drive_item(input doq_in_item_t it);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        // hold until the transfer happens
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [47:0] dl,
                           input logic [31:0] tid, input logic [15:0] own,
                           input logic [47:0] now);
        doq_in_item_t it;
        it.operation      = op;
        it.deadline       = dl;
        it.timer_ident    = tid;
        it.instance_ident = own;
        it.now_time       = now;
        drive_item(it);
    endtask

    task automatic gen_item(output doq_in_item_t it);
        int r;
        // unused fields carry noise
        it.operation      = OP_W'($urandom_range(3));
        it.deadline       = rand48();
        it.timer_ident    = $urandom;
        it.instance_ident = 16'($urandom);
        it.now_time       = rand48();
        if ($urandom_range(99) >= 10) begin
            r = $urandom_range(99);
            if (r < insert_pct) begin
                it.operation      = OP_INSERT;
                it.deadline       = base_time + 48'($urandom_range(0, 120));
                it.timer_ident    = timer_pool[$urandom_range(7)];
                it.instance_ident = owner_pool[$urandom_range(3)];
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    it.operation = OP_TICK;
                    it.now_time  = base_time + 48'($urandom_range(0, 150));
                    base_time    = base_time + 48'($urandom_range(0, 40));
                end else if (r < 80) begin
                    it.operation   = OP_REMOVE_ID;
                    it.timer_ident = timer_pool[$urandom_range(7)];
                end else begin
                    it.operation      = OP_REMOVE_OWN;
                    it.instance_ident = owner_pool[$urandom_range(3)];
                end
            end
        end
    endtask

    initial begin : stimulus
        doq_in_item_t it;
        int           guard;
        int           phase_idle [4];
        int           phase_stall [4];

        phase_idle  = '{0, 61, 0, 30};
        phase_stall = '{0, 0, 61, 30};
        foreach (timer_pool[i]) timer_pool[i] = $urandom;
        foreach (owner_pool[i]) owner_pool[i] = 16'($urandom);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue: tick and both removes do nothing
        send_op(OP_TICK, '0, '0, '0, '1);
        send_op(OP_REMOVE_ID, '0, '0, '0, '0);
        send_op(OP_REMOVE_OWN, '0, '0, '0, '0);
        // field extremes and equal deadlines
        send_op(OP_INSERT, '0, '0, '0, '0);
        send_op(OP_INSERT, '1, '1, '1, '0);
        send_op(OP_INSERT, 48'd100, 32'hA, 16'd1, '0);
        send_op(OP_INSERT, 48'd100, 32'hB, 16'd1, '0);
        // head equal to now is not due; strictly earlier fires
        send_op(OP_TICK, '0, '0, '0, 48'd0);
        send_op(OP_TICK, '0, '0, '0, 48'd1);
        send_op(OP_TICK, '0, '0, '0, 48'd100);
        send_op(OP_TICK, '0, '0, '0, 48'd101);
        // fill up, then one insert into the full queue
        for (int i = 0; i < 15; i++)
            send_op(OP_INSERT, 48'd200 + 48'(i), (i % 2 == 0) ? 32'd5 : 32'd6,
                    16'd7, '0);
        // scattered matches, then a run of adjacent ones
        send_op(OP_REMOVE_ID, '0, 32'd5, '0, '0);
        send_op(OP_REMOVE_OWN, '0, '0, 16'd7, '0);
        send_op(OP_REMOVE_ID, '0, '1, '0, '0);

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = phase_idle[p];
            rx_stall_pct <= phase_stall[p];
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // alternate filling and draining stretches
                insert_pct = ((k / 48) % 2 == 1) ? 75 : 35;
                if (p == 0 && k == 100)
                    hold_req <= hold_req + 1;
                gen_item(it);
                drive_item(it);
            end
        end
        s_valid <= 1'b0;

        guard = 0;
        while (pending_results != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
